/* hw/rtl/olsp_pkg.sv */
// offer list stream parser: shared types, phase codes and result codes
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package olsp_pkg;

  typedef enum logic [3:0] {
    PH_PRESENCE = 4'd0,
    PH_STIME    = 4'd1,
    PH_HEAD     = 4'd2,
    PH_NAME     = 4'd3,
    PH_PREV     = 4'd4,
    PH_WORLD    = 4'd5,
    PH_TIME     = 4'd6,
    PH_PRICE    = 4'd7,
    PH_QTY      = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_END  = 1'b1;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_NAME   = 3'd1;
  localparam logic [2:0] KIND_PREV   = 3'd2;
  localparam logic [2:0] KIND_RECORD = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // last byte position of each multi-byte field
  localparam logic [2:0] LAST_STIME = 3'd7;
  localparam logic [2:0] LAST_HEAD  = 3'd4;
  localparam logic [2:0] LAST_WORLD = 3'd1;
  localparam logic [2:0] LAST_TIME  = 3'd7;
  localparam logic [2:0] LAST_PRICE = 3'd3;
  localparam logic [2:0] LAST_QTY   = 3'd3;

  typedef struct packed {
    logic               operation;
    logic [7:0]         data_byte;
    logic signed [63:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic [15:0]        offer_index;
    logic [7:0]         text_byte;
    logic [15:0]        item_id;
    logic               sell_flag;
    logic [15:0]        offer_total;
    logic [15:0]        world;
    logic signed [63:0] offer_time;
    logic signed [31:0] price;
    logic signed [31:0] quantity;
    logic signed [63:0] clock_offset;
    logic [1:0]         status;
  } out_beat_t;

endpackage

`default_nettype wire

/* hw/rtl/olsp_if.sv */
// offer list stream parser: valid/ready channel interfaces for input and result beats
// depends on olsp_pkg
`default_nettype none

interface olsp_in_if;
  logic               valid;
  logic               ready;
  olsp_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface olsp_out_if;
  logic                valid;
  logic                ready;
  olsp_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/offer_list_stream_parser_top.sv */
// offer list stream parser top level: byte-wise parse of a big-endian offer-list message
// depends on olsp_pkg and the channel interfaces in olsp_if.sv
`default_nettype none

// The parser takes one beat per clock cycle: a message byte or an end-of-buffer marker.
// Each accepted beat updates the parse state in the same cycle and, when it produces a
// result (header, kept name byte, offer record or final status), loads it into the output
// register, so a result appears in the cycle after its beat. A new beat is accepted whenever
// the output register is empty or is being drained, so the sustained rate is one beat per
// cycle as long as the result side keeps taking beats. Names longer than TEXT_CAP-1
// characters are cut; the remainder is consumed without results. After an end beat the
// parser is back in its reset state, ready for the next message.
module offer_list_stream_parser_top #(
  parameter int TEXT_CAP = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  olsp_in_if.sink    in_ch,
  olsp_out_if.source out_ch
);

  localparam int LEN_W = $clog2(TEXT_CAP);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TEXT_CAP - 1);

  olsp_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]          pos_r, pos_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [63:0]         stime_r, stime_nxt;
  logic [15:0]         left_r, left_nxt;
  logic [15:0]         cur_r, cur_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [15:0]         world_r, world_nxt;
  logic [63:0]         time_r, time_nxt;
  logic [31:0]         price_r, price_nxt;
  logic                present_r, present_nxt;
  logic                out_valid_r, out_valid_nxt;
  olsp_pkg::out_beat_t out_r, out_nxt;

  olsp_pkg::out_beat_t res;
  logic                res_valid;
  logic                accept;
  logic [7:0]          b;
  logic [63:0]         shifted;
  logic [2:0]          last_pos;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign b            = in_ch.data.data_byte;
  assign shifted      = {acc_r[55:0], b};

  always_comb begin
    unique case (phase_r)
      olsp_pkg::PH_STIME: last_pos = olsp_pkg::LAST_STIME;
      olsp_pkg::PH_HEAD:  last_pos = olsp_pkg::LAST_HEAD;
      olsp_pkg::PH_WORLD: last_pos = olsp_pkg::LAST_WORLD;
      olsp_pkg::PH_TIME:  last_pos = olsp_pkg::LAST_TIME;
      olsp_pkg::PH_PRICE: last_pos = olsp_pkg::LAST_PRICE;
      default:            last_pos = olsp_pkg::LAST_QTY;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    stime_nxt   = stime_r;
    left_nxt    = left_r;
    cur_nxt     = cur_r;
    len_nxt     = len_r;
    world_nxt   = world_r;
    time_nxt    = time_r;
    price_nxt   = price_r;
    present_nxt = present_r;
    res         = '0;
    res_valid   = 1'b0;

    if (in_ch.data.operation == olsp_pkg::OP_END) begin
      res_valid        = 1'b1;
      res.result_kind  = olsp_pkg::KIND_STATUS;
      if (phase_r != olsp_pkg::PH_DONE) begin
        res.status = olsp_pkg::ST_TRUNCATED;
      end else if (!present_r) begin
        res.status = olsp_pkg::ST_ABSENT;
      end else begin
        res.status       = olsp_pkg::ST_LOADED;
        res.clock_offset = in_ch.data.now_ms - stime_r;
      end
      phase_nxt   = olsp_pkg::PH_PRESENCE;
      pos_nxt     = '0;
      acc_nxt     = '0;
      stime_nxt   = '0;
      left_nxt    = '0;
      cur_nxt     = '0;
      len_nxt     = '0;
      world_nxt   = '0;
      time_nxt    = '0;
      price_nxt   = '0;
      present_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        olsp_pkg::PH_DONE: begin
        end
        olsp_pkg::PH_PRESENCE: begin
          if (b == 8'd1) begin
            phase_nxt = olsp_pkg::PH_STIME;
            pos_nxt   = '0;
            acc_nxt   = '0;
          end else begin
            present_nxt = 1'b0;
            phase_nxt   = olsp_pkg::PH_DONE;
          end
        end
        olsp_pkg::PH_NAME, olsp_pkg::PH_PREV: begin
          if (b == 8'd0) begin
            len_nxt   = '0;
            acc_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = (phase_r == olsp_pkg::PH_NAME) ? olsp_pkg::PH_PREV
                                                       : olsp_pkg::PH_WORLD;
          end else if (len_r < LEN_MAX) begin
            len_nxt         = len_r + 1'b1;
            res_valid       = 1'b1;
            res.result_kind = (phase_r == olsp_pkg::PH_NAME) ? olsp_pkg::KIND_NAME
                                                             : olsp_pkg::KIND_PREV;
            res.offer_index = cur_r;
            res.text_byte   = b;
          end
        end
        default: begin
          if (pos_r != last_pos) begin
            acc_nxt = shifted;
            pos_nxt = pos_r + 1'b1;
          end else begin
            acc_nxt = '0;
            pos_nxt = '0;
            unique case (phase_r)
              olsp_pkg::PH_STIME: begin
                stime_nxt = shifted;
                phase_nxt = olsp_pkg::PH_HEAD;
              end
              olsp_pkg::PH_HEAD: begin
                res_valid       = 1'b1;
                res.result_kind = olsp_pkg::KIND_HEADER;
                res.item_id     = shifted[39:24];
                res.sell_flag   = (shifted[23:16] == 8'd1);
                res.offer_total = shifted[15:0];
                left_nxt        = shifted[15:0];
                cur_nxt         = '0;
                len_nxt         = '0;
                if (shifted[15:0] == 16'd0) begin
                  present_nxt = 1'b1;
                  phase_nxt   = olsp_pkg::PH_DONE;
                end else begin
                  phase_nxt = olsp_pkg::PH_NAME;
                end
              end
              olsp_pkg::PH_WORLD: begin
                world_nxt = shifted[15:0];
                phase_nxt = olsp_pkg::PH_TIME;
              end
              olsp_pkg::PH_TIME: begin
                time_nxt  = shifted;
                phase_nxt = olsp_pkg::PH_PRICE;
              end
              olsp_pkg::PH_PRICE: begin
                price_nxt = shifted[31:0];
                phase_nxt = olsp_pkg::PH_QTY;
              end
              default: begin
                res_valid       = 1'b1;
                res.result_kind = olsp_pkg::KIND_RECORD;
                res.offer_index = cur_r;
                res.world       = world_r;
                res.offer_time  = time_r;
                res.price       = price_r;
                res.quantity    = shifted[31:0];
                cur_nxt         = cur_r + 16'd1;
                left_nxt        = left_r - 16'd1;
                len_nxt         = '0;
                if (left_r == 16'd1) begin
                  present_nxt = 1'b1;
                  phase_nxt   = olsp_pkg::PH_DONE;
                end else begin
                  phase_nxt = olsp_pkg::PH_NAME;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (accept) begin
      out_valid_nxt = res_valid;
      out_nxt       = res;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= olsp_pkg::PH_PRESENCE;
      pos_r       <= '0;
      acc_r       <= '0;
      stime_r     <= '0;
      left_r      <= '0;
      cur_r       <= '0;
      len_r       <= '0;
      world_r     <= '0;
      time_r      <= '0;
      price_r     <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        acc_r     <= acc_nxt;
        stime_r   <= stime_nxt;
        left_r    <= left_nxt;
        cur_r     <= cur_nxt;
        len_r     <= len_nxt;
        world_r   <= world_nxt;
        time_r    <= time_nxt;
        price_r   <= price_nxt;
        present_r <= present_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_end_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.data.operation == olsp_pkg::OP_END
      |=> out_valid_r && out_r.result_kind == olsp_pkg::KIND_STATUS)
    else $error("end beat did not produce a status result");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.data.operation == olsp_pkg::OP_END
      |=> phase_r == olsp_pkg::PH_PRESENCE && pos_r == 3'd0)
    else $error("parser not restarted after end beat");

  a_done_no_offers_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == olsp_pkg::PH_DONE |-> left_r == 16'd0)
    else $error("message complete with offers outstanding");

  a_name_len_capped: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("kept name length exceeds cap");

  a_status_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.result_kind != olsp_pkg::KIND_STATUS
      |-> out_r.status == olsp_pkg::ST_LOADED && out_r.clock_offset == 64'd0)
    else $error("status fields set on a non-status result");

endmodule

`default_nettype wire

/* tb/sv/tb_offer_list_stream_parser_top.sv */
`timescale 1ns / 100ps
// testbench for the offer list stream parser: a directed table, then random messages
// checked beat by beat against an in-bench parse of the same byte stream
// depends on olsp_pkg, the channel interfaces and the parser top level
module tb_offer_list_stream_parser_top;
  import olsp_pkg::*;

  localparam int NAME_CAP = 32;

  typedef struct {
    in_beat_t  beat;
    bit        pinned;
    bit        has;
    out_beat_t want;
  } row_t;

  logic clk;
  logic rst_n;

  olsp_in_if  in_ch ();
  olsp_out_if out_ch ();

  offer_list_stream_parser_top #(.TEXT_CAP(NAME_CAP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parse state of the bench's own copy of the parser
  phase_t      stage;
  int          nbytes;
  logic [63:0] acc;
  logic [63:0] srv_time;
  logic [15:0] left_cnt;
  logic [15:0] offer_no;
  int          name_len;
  logic [15:0] world_hold;
  logic [63:0] time_hold;
  logic [31:0] price_hold;
  bit          list_on;
  bit          msg_done;

  out_beat_t   pending_results[$];
  row_t        pinned_results[$];
  row_t        script[$];
  logic [7:0]  msg_bytes[$];

  int mismatches = 0;
  int rdy_mode   = 0;
  int tick       = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_offer_list_stream_parser_top NOT OK");
    $finish;
  end

  function automatic void clear_parse();
    stage      = PH_PRESENCE;
    nbytes     = 0;
    acc        = '0;
    srv_time   = '0;
    left_cnt   = '0;
    offer_no   = '0;
    name_len   = 0;
    world_hold = '0;
    time_hold  = '0;
    price_hold = '0;
    list_on    = 1'b0;
    msg_done   = 1'b0;
  endfunction

  function automatic void close_msg(bit present);
    list_on  = present;
    msg_done = 1'b1;
    stage    = PH_DONE;
  endfunction

  function automatic void parse_beat(input in_beat_t b, output bit emits, output out_beat_t r);
    logic [7:0]  d;
    logic [63:0] v;
    int          need;
    d     = b.data_byte;
    emits = 1'b0;
    r     = '0;
    if (b.operation == OP_END) begin
      emits = 1'b1;
      r.result_kind = KIND_STATUS;
      if (!msg_done) begin
        r.status = ST_TRUNCATED;
      end else if (!list_on) begin
        r.status = ST_ABSENT;
      end else begin
        r.clock_offset = b.now_ms - srv_time;
        r.status = ST_LOADED;
      end
      clear_parse();
      return;
    end
    if (msg_done) return;
    case (stage)
      PH_PRESENCE: begin
        if (d == 8'd1) begin
          stage  = PH_STIME;
          nbytes = 0;
          acc    = '0;
        end else begin
          close_msg(1'b0);
        end
      end
      PH_NAME, PH_PREV: begin
        if (d == 8'd0) begin
          name_len = 0;
          acc      = '0;
          nbytes   = 0;
          if (stage == PH_NAME) stage = PH_PREV;
          else stage = PH_WORLD;
        end else if (name_len + 1 < NAME_CAP) begin
          name_len++;
          emits = 1'b1;
          if (stage == PH_NAME) r.result_kind = KIND_NAME;
          else r.result_kind = KIND_PREV;
          r.offer_index = offer_no;
          r.text_byte   = d;
        end
      end
      default: begin
        case (stage)
          PH_STIME, PH_TIME: need = 8;
          PH_HEAD:           need = 5;
          PH_WORLD:          need = 2;
          default:           need = 4;
        endcase
        acc = {acc[55:0], d};
        nbytes++;
        if (nbytes == need) begin
          v      = acc;
          acc    = '0;
          nbytes = 0;
          case (stage)
            PH_STIME: begin
              srv_time = v;
              stage    = PH_HEAD;
            end
            PH_HEAD: begin
              emits         = 1'b1;
              r.result_kind = KIND_HEADER;
              r.item_id     = v[39:24];
              r.sell_flag   = (v[23:16] == 8'd1);
              r.offer_total = v[15:0];
              left_cnt      = v[15:0];
              offer_no      = '0;
              name_len      = 0;
              if (left_cnt == 16'd0) close_msg(1'b1);
              else stage = PH_NAME;
            end
            PH_WORLD: begin
              world_hold = v[15:0];
              stage      = PH_TIME;
            end
            PH_TIME: begin
              time_hold = v;
              stage     = PH_PRICE;
            end
            PH_PRICE: begin
              price_hold = v[31:0];
              stage      = PH_QTY;
            end
            default: begin
              emits         = 1'b1;
              r.result_kind = KIND_RECORD;
              r.offer_index = offer_no;
              r.world       = world_hold;
              r.offer_time  = time_hold;
              r.price       = price_hold;
              r.quantity    = v[31:0];
              offer_no      = offer_no + 16'd1;
              left_cnt      = left_cnt - 16'd1;
              name_len      = 0;
              if (left_cnt == 16'd0) close_msg(1'b1);
              else stage = PH_NAME;
            end
          endcase
        end
      end
    endcase
  endfunction

  function automatic void cmp_field(string tag, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, tag, want, got);
      mismatches++;
    end
  endfunction

  // scoreboard: results against the oldest expectation, accepted beats into the parse
  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    out_beat_t got;
    out_beat_t guess;
    bit        hit;
    row_t      note;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("result_kind", want.result_kind, got.result_kind);
          cmp_field("offer_index", want.offer_index, got.offer_index);
          cmp_field("text_byte", want.text_byte, got.text_byte);
          cmp_field("item_id", want.item_id, got.item_id);
          cmp_field("sell_flag", want.sell_flag, got.sell_flag);
          cmp_field("offer_total", want.offer_total, got.offer_total);
          cmp_field("world", want.world, got.world);
          cmp_field("offer_time", want.offer_time, got.offer_time);
          cmp_field("price", want.price, got.price);
          cmp_field("quantity", want.quantity, got.quantity);
          cmp_field("clock_offset", want.clock_offset, got.clock_offset);
          cmp_field("status", want.status, got.status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_beat(in_ch.data, hit, guess);
        note = pinned_results.pop_front();
        if (note.pinned) begin
          if (note.has) pending_results.push_back(note.want);
        end else if (hit) begin
          pending_results.push_back(guess);
        end
      end
    end
  end

  // result side stall patterns
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      case (rdy_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ((tick % 11) > 3);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic row_t step_row(logic op, logic [7:0] d, logic [63:0] now, bit pinned,
                                    bit has, out_beat_t want);
    row_t rw;
    rw.beat.operation = op;
    rw.beat.data_byte = d;
    rw.beat.now_ms    = now;
    rw.pinned         = pinned;
    rw.has            = has;
    rw.want           = want;
    return rw;
  endfunction

  function automatic out_beat_t status_of(logic [1:0] st, logic [63:0] off);
    out_beat_t r;
    r              = '0;
    r.result_kind  = KIND_STATUS;
    r.status       = st;
    r.clock_offset = off;
    return r;
  endfunction

  function automatic out_beat_t header_of(logic [15:0] item, logic sell, logic [15:0] total);
    out_beat_t r;
    r             = '0;
    r.result_kind = KIND_HEADER;
    r.item_id     = item;
    r.sell_flag   = sell;
    r.offer_total = total;
    return r;
  endfunction

  function automatic logic [63:0] spice64();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_name(int len);
    repeat (len) msg_bytes.push_back($urandom_range(1, 255));
    msg_bytes.push_back(8'd0);
  endfunction

  function automatic int name_len_pick();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 6);
    return $urandom_range(28, 40);
  endfunction

  // fills msg_bytes with one message; returns its byte count plus one for the end beat, trailing extra bytes excluded
  function automatic int build_message(bit forced);
    int         style;
    int         count;
    int         made;
    int         cut;
    int         nb;
    logic [7:0] pb;
    msg_bytes.delete();
    style = forced ? 2 : $urandom_range(0, 19);
    if (style == 0) begin
      do pb = $urandom_range(0, 255); while (pb == 8'd1);
      msg_bytes.push_back(pb);
    end else if (style == 1) begin
      repeat ($urandom_range(0, 12)) msg_bytes.push_back($urandom_range(0, 255));
    end else begin
      msg_bytes.push_back(8'd1);
      push_be(spice64(), 8);
      push_be(forced ? 64'hFFFF : $urandom, 2);
      push_be(forced ? 64'd0 : ($urandom_range(0, 1) ? 64'd1 : $urandom_range(0, 255)), 1);
      case ($urandom_range(0, 15))
        0:               count = 0;
        13:              count = 4;
        14, 15:          count = $urandom_range(0, 65535);
        default:         count = $urandom_range(1, 3);
      endcase
      if (forced) count = 1;
      push_be(count, 2);
      made = (count > 4) ? $urandom_range(0, 2) : count;
      for (int k = 0; k < made; k++) begin
        push_name(forced ? NAME_CAP + 1 : name_len_pick());
        push_name(forced ? NAME_CAP - 1 : name_len_pick());
        push_be(forced ? 64'hFFFF : $urandom, 2);
        push_be(forced ? '1 : spice64(), 8);
        push_be(forced ? 64'h8000_0000 : spice64() >> 32, 4);
        push_be(forced ? 64'h7FFF_FFFF : spice64() >> 32, 4);
      end
    end
    if (!forced && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, msg_bytes.size());
      while (msg_bytes.size() > cut) msg_bytes.delete(msg_bytes.size() - 1);
    end
    nb = msg_bytes.size() + 1;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) msg_bytes.push_back($urandom_range(0, 255));
    return nb;
  endfunction

  task automatic send(input row_t rw);
    pinned_results.push_back(rw);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= rw.beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    int        items;
    int        msg_no;
    out_beat_t none;
    row_t      rw;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    none = '0;
    clear_parse();

    // after reset, absent list, trailing bytes, zero offers at the extremes, early ends
    script.push_back(step_row(OP_END, 8'h00, 64'd0, 1, 1, status_of(ST_TRUNCATED, 64'd0)));
    script.push_back(step_row(OP_BYTE, 8'h00, '1, 1, 0, none));
    script.push_back(step_row(OP_BYTE, 8'hFF, '1, 1, 0, none));
    script.push_back(step_row(OP_END, 8'hFF, 64'h8000_0000_0000_0000, 1, 1,
                              status_of(ST_ABSENT, 64'd0)));
    script.push_back(step_row(OP_BYTE, 8'h01, 64'd0, 0, 0, none));
    for (int i = 0; i < 8; i++)
      script.push_back(step_row(OP_BYTE, (i == 0) ? 8'h80 : 8'h00, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_BYTE, 8'hFF, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_BYTE, 8'hFF, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_BYTE, 8'h01, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_BYTE, 8'h00, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_BYTE, 8'h00, 64'd0, 1, 1, header_of(16'hFFFF, 1'b1, 16'd0)));
    script.push_back(step_row(OP_BYTE, 8'hAB, 64'd0, 1, 0, none));
    script.push_back(step_row(OP_END, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1,
                              status_of(ST_LOADED, '1)));
    script.push_back(step_row(OP_BYTE, 8'h01, 64'd0, 0, 0, none));
    script.push_back(step_row(OP_END, 8'h00, '1, 1, 1, status_of(ST_TRUNCATED, 64'd0)));
    script.push_back(step_row(OP_END, 8'h00, '1, 1, 1, status_of(ST_TRUNCATED, 64'd0)));
    script.push_back(step_row(OP_BYTE, 8'h03, 64'd0, 1, 0, none));
    script.push_back(step_row(OP_END, 8'h00, 64'd5, 1, 1, status_of(ST_ABSENT, 64'd0)));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send(script[i]);
    drain_results();

    items  = 0;
    msg_no = 0;
    while (items < 1250) begin
      if (msg_no % 8 == 0) begin
        rdy_mode = $urandom_range(0, 3);
        gaps_on  = ($urandom_range(0, 3) != 0);
      end
      if (msg_no % 25 == 12) drain_results();
      items += build_message(msg_no == 0);
      foreach (msg_bytes[i]) begin
        rw = step_row(OP_BYTE, msg_bytes[i], {$urandom, $urandom}, 0, 0, none);
        send(rw);
      end
      rw = step_row(OP_END, $urandom_range(0, 255), spice64(), 0, 0, none);
      send(rw);
      msg_no++;
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_offer_list_stream_parser_top OK");
    end else begin
      $display("tb_offer_list_stream_parser_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/olsp_pkg.sv
hw/rtl/olsp_if.sv
hw/rtl/offer_list_stream_parser_top.sv
tb/sv/tb_offer_list_stream_parser_top.sv
